[rtl/prrts_pkg.sv]
package prrts_pkg;

  // Table geometry
  localparam int MAX_TASKS_DEF = 16;

  // Field widths fixed by the item format
  localparam int SLOT_W  = 4;
  localparam int RUN_W   = 5;
  localparam int PRIO_W  = 8;
  localparam int TICK_W  = 32;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 8;

  // Running slot code that means no task runs
  localparam logic [RUN_W-1:0] NO_RUNNING = 5'd16;

  // Operation codes carried in tuser
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // One task slot as stored in the table
  typedef struct packed {
    logic              present;
    logic              ready;
    logic [PRIO_W-1:0] prio;
    logic              periodic;
    logic [TICK_W-1:0] release_tick;
  } task_entry_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_DRAIN1,
    S_START2,
    S_SCAN2,
    S_DRAIN2,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // latch select fields, restart first pass
    logic write;   // write one table slot
    logic issue;   // issue one table read
    logic pass2;   // read belongs to the second pass
    logic start2;  // set up the second pass
    logic emit;    // hand the result to the output register
  } ctrl_cmd_t;

  // Status from datapath and output side to controller
  typedef struct packed {
    logic last_issue;
    logic out_free;
  } ctrl_sts_t;

  // Selection result
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              idle;
  } sel_res_t;

endpackage

[rtl/prrts_ctrl.sv]
module prrts_ctrl
  import prrts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_SELECT) state_nxt = S_SCAN1;
      end
      S_SCAN1: begin
        if (sts.last_issue) state_nxt = S_DRAIN1;
      end
      S_DRAIN1: state_nxt = S_START2;
      S_START2: state_nxt = S_SCAN2;
      S_SCAN2: begin
        if (sts.last_issue) state_nxt = S_DRAIN2;
      end
      S_DRAIN2: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.load   = in_valid && in_op == OP_SELECT;
        cmd.write  = in_valid && in_op == OP_UPDATE;
      end
      S_SCAN1: begin
        cmd.issue = 1'b1;
      end
      S_START2: begin
        cmd.start2 = 1'b1;
      end
      S_SCAN2: begin
        cmd.issue = 1'b1;
        cmd.pass2 = 1'b1;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/prrts_dp.sv]
module prrts_dp
  import prrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  input  logic [SLOT_W-1:0] wr_slot,
  input  task_entry_t       wr_entry,
  input  logic [TICK_W-1:0] now_tick,
  input  logic [RUN_W-1:0]  running_slot,
  output logic              last_issue,
  output sel_res_t          res
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  task_entry_t mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_r;

  logic [TICK_W-1:0] now_r;
  logic [RUN_W-1:0]  run_r;
  logic [IDX_W-1:0]  addr_r, cnt_r;
  logic              rd_vld_r, rd_pass2_r, rd_valid_bit_r;
  logic [IDX_W-1:0]  rd_idx_r;
  task_entry_t       rd_data_r;
  logic [PRIO_W-1:0] best_r, run_prio_r;
  logic              found_r;
  logic [IDX_W-1:0]  pick_r;

  logic              wr_ok;
  logic              run_ok;
  logic [IDX_W-1:0]  run_idx, run_next, addr_next;
  task_entry_t       rd_entry;
  logic [TICK_W-1:0] diff;
  logic              eligible;

  assign wr_ok     = 32'(wr_slot) < 32'(MAX_TASKS);
  assign run_ok    = (32'(run_r) < 32'(MAX_TASKS)) && (run_r != NO_RUNNING);
  assign run_idx   = IDX_W'(run_r);
  assign run_next  = (run_idx == LAST_IDX) ? '0 : run_idx + 1'b1;
  assign addr_next = (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;
  assign last_issue = cnt_r == LAST_IDX;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[IDX_W'(wr_slot)] <= wr_entry;
    end
    rd_data_r <= mem[addr_r];
  end

  // Written marks: an unwritten slot reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write && wr_ok) begin
      valid_r[IDX_W'(wr_slot)] <= 1'b1;
    end
  end

  // Read tracking and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_pass2_r     <= cmd.pass2;
    rd_idx_r       <= addr_r;
    rd_valid_bit_r <= valid_r[addr_r];
    if (cmd.load) begin
      addr_r <= '0;
      cnt_r  <= '0;
      now_r  <= now_tick;
      run_r  <= running_slot;
    end else if (cmd.start2) begin
      addr_r <= (run_ok && run_prio_r == best_r) ? run_next : '0;
      cnt_r  <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_next;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Eligibility of the slot just read
  assign rd_entry = rd_valid_bit_r ? rd_data_r : '0;
  assign diff     = now_r - rd_entry.release_tick;
  assign eligible = rd_entry.present && rd_entry.ready &&
                    (!rd_entry.periodic || !diff[TICK_W-1]);

  // First pass: highest priority and running slot priority
  // Second pass: first match from the start point
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_r     <= '0;
      run_prio_r <= '0;
      found_r    <= 1'b0;
      pick_r     <= '0;
    end else if (rd_vld_r && !rd_pass2_r) begin
      if (eligible && rd_entry.prio > best_r) begin
        best_r <= rd_entry.prio;
      end
      if (32'(rd_idx_r) == 32'(run_r)) begin
        run_prio_r <= rd_entry.prio;
      end
    end else if (rd_vld_r && rd_pass2_r) begin
      if (!found_r && best_r != '0 && eligible && rd_entry.prio == best_r) begin
        found_r <= 1'b1;
        pick_r  <= rd_idx_r;
      end
    end
  end

  assign res.slot = found_r ? SLOT_W'(pick_r) : '0;
  assign res.idle = !found_r;

endmodule

[rtl/priority_round_robin_task_select_top.sv]
// Channel  Ports         Direction  Contents
// in       in_t*         slave      update or select item
// out      out_t*        master     chosen slot or idle
//
// An update item is taken whenever the block is idle. A select item makes
// two passes over the task table through its single read port, one slot per
// cycle. The next item is accepted in the cycle after the result is handed
// to the output register.
// Reset (rst_n, synchronous) empties the table and clears control state.
// The result waits in an output register; the next item is accepted
// meanwhile, and a following select result waits until it is taken.
module priority_round_robin_task_select_top
  import prrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // slot[3:0] present[4] ready_req[5] priority_req[13:6] periodic[14]
  // release_time[46:15] now_tick[78:47] running_slot[83:79] zero[87:84]
  input  logic [IN_W-1:0] in_tdata,
  // operation[0]
  input  logic            in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // chosen_slot[3:0] zero[7:4]
  output logic [OUT_W-1:0] out_tdata,
  // choose_idle[0]
  output logic             out_tuser
);

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  sel_res_t    res;
  task_entry_t wr_entry;
  logic        last_issue;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_idle_r;

  // Unpack the input item
  assign wr_entry.present      = in_tdata[4];
  assign wr_entry.ready        = in_tdata[5];
  assign wr_entry.prio         = in_tdata[13:6];
  assign wr_entry.periodic     = in_tdata[14];
  assign wr_entry.release_tick = in_tdata[46:15];

  assign sts.last_issue = last_issue;
  assign sts.out_free   = !out_valid_r || out_tready;

  prrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .wr_slot      (in_tdata[3:0]),
    .wr_entry     (wr_entry),
    .now_tick     (in_tdata[78:47]),
    .running_slot (in_tdata[83:79]),
    .last_issue   (last_issue),
    .res          (res)
  );

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r <= res.slot;
      out_idle_r <= res.idle;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - SLOT_W){1'b0}}, out_slot_r};
  assign out_tuser  = out_idle_r;

endmodule

[sim/tb.sv]
module tb;
  import prrts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One item as the sender sees it, before packing onto the stream
  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic              present;
    logic              ready;
    logic [PRIO_W-1:0] prio;
    logic              periodic;
    logic [TICK_W-1:0] release_tick;
    logic [TICK_W-1:0] now_tick;
    logic [RUN_W-1:0]  run;
  } sched_item_t;

  // Directed row: item plus an optional hand-written pick
  typedef struct packed {
    sched_item_t item;
    logic        typed;
    sel_res_t    want;
  } dir_row_t;

  localparam sel_res_t IDLE_PICK = '{4'd0, 1'b1};
  localparam int RANDOM_ITEMS = 875;
  localparam int CALM_FROM = 725;
  localparam int HOLD_AT = 300;
  localparam int HOLD_BURST = 12;
  localparam int LONG_HOLD = 500;
  localparam int N_DIRECTED = 25;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // empty table
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, NO_RUNNING}, 1'b1, IDLE_PICK},
    // only a priority-zero task
    '{'{OP_UPDATE, 4'd0, 1'b1, 1'b1, 8'd0, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b1, IDLE_PICK},
    // top priority in the last slot
    '{'{OP_UPDATE, 4'd15, 1'b1, 1'b1, 8'hFF, 1'b0, 32'hFFFF_FFFF, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, NO_RUNNING},
      1'b1, '{4'd15, 1'b0}},
    // second top-priority task: rotate between slots 3 and 15
    '{'{OP_UPDATE, 4'd3, 1'b1, 1'b1, 8'hFF, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, NO_RUNNING},
      1'b1, '{4'd3, 1'b0}},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd3}, 1'b1, '{4'd15, 1'b0}},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd15}, 1'b1, '{4'd3, 1'b0}},
    // running code above the table means no running task
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd31}, 1'b1, '{4'd3, 1'b0}},
    // running slot absent but holding the top priority
    '{'{OP_UPDATE, 4'd7, 1'b0, 1'b1, 8'hFF, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd7}, 1'b0, '0},
    // blocked task drops out
    '{'{OP_UPDATE, 4'd3, 1'b1, 1'b0, 8'hFF, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, NO_RUNNING},
      1'b1, '{4'd15, 1'b0}},
    // periodic gate just before and at the release tick
    '{'{OP_UPDATE, 4'd15, 1'b1, 1'b1, 8'hFF, 1'b1, 32'd1000, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd999, NO_RUNNING}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd1000, NO_RUNNING}, 1'b0, '0},
    // signed distance at its extremes
    '{'{OP_UPDATE, 4'd15, 1'b1, 1'b1, 8'hFF, 1'b1, 32'd0, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'h7FFF_FFFF, NO_RUNNING}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'h8000_0000, NO_RUNNING}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd15, 1'b1, 1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'd0, 5'd0}, 1'b0, '0},
    '{'{OP_SELECT, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, NO_RUNNING}, 1'b0, '0},
    // unused fields loaded with ones
    '{'{OP_UPDATE, 4'd9, 1'b1, 1'b1, 8'd1, 1'b0, 32'd5, 32'hFFFF_FFFF, 5'd31}, 1'b0, '0},
    '{'{OP_SELECT, 4'd15, 1'b1, 1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 5'd9},
      1'b0, '0},
    '{'{OP_UPDATE, 4'd15, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 5'd0}, 1'b0, '0}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  task_entry_t      sched_table [MAX_TASKS_DEF];
  sel_res_t         pending_picks [$];
  int unsigned      mismatch_count = 0;
  logic [RUN_W-1:0] last_run = NO_RUNNING;
  logic [TICK_W-1:0] tick_base;
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;

  priority_round_robin_task_select_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5ns clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Task may run: present, ready, and at or past its release tick when periodic
  function automatic logic runnable(input int i, input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] lag;
    lag = now - sched_table[i].release_tick;
    return sched_table[i].present && sched_table[i].ready &&
           !(sched_table[i].periodic && lag[TICK_W-1]);
  endfunction

  // Pick the next task: highest runnable priority, rotating after the running one
  function automatic sel_res_t select_task(input logic [TICK_W-1:0] now,
                                           input logic [RUN_W-1:0] run);
    logic [PRIO_W-1:0] top;
    logic              hit;
    int                j;
    sel_res_t          res;
    top = '0;
    hit = 1'b0;
    res = '0;
    for (int i = 0; i < MAX_TASKS_DEF; i++) begin
      if (runnable(i, now) && sched_table[i].prio > top) begin
        top = sched_table[i].prio;
      end
    end
    if (top != '0) begin
      if (run < MAX_TASKS_DEF && sched_table[run[SLOT_W-1:0]].prio == top) begin
        for (int k = 1; k < MAX_TASKS_DEF && !hit; k++) begin
          j = (int'(run) + k) % MAX_TASKS_DEF;
          if (runnable(j, now) && sched_table[j].prio == top) begin
            hit = 1'b1;
            res.slot = j[SLOT_W-1:0];
          end
        end
      end
      for (int i = 0; i < MAX_TASKS_DEF && !hit; i++) begin
        if (runnable(i, now) && sched_table[i].prio == top) begin
          hit = 1'b1;
          res.slot = i[SLOT_W-1:0];
        end
      end
    end
    res.idle = !hit;
    return res;
  endfunction

  // Offer one item, hold it until taken, then update the table copy or queue the predicted pick
  task automatic offer_item(input sched_item_t it, input logic typed, input sel_res_t typed_res);
    sel_res_t res;
    in_tuser  <= it.op;
    in_tdata  <= {4'd0, it.run, it.now_tick, it.release_tick, it.periodic, it.prio,
                  it.ready, it.present, it.slot};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (it.op == OP_UPDATE) begin
      sched_table[it.slot] = '{it.present, it.ready, it.prio, it.periodic, it.release_tick};
    end else begin
      res = select_task(it.now_tick, it.run);
      last_run = res.idle ? NO_RUNNING : {1'b0, res.slot};
      pending_picks.push_back(typed ? typed_res : res);
    end
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [PRIO_W-1:0] random_prio();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_W'($urandom_range(1, 3));
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  // Tick close to the current base most of the time, anywhere otherwise
  function automatic logic [TICK_W-1:0] random_tick();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom;
    end
    return tick_base + TICK_W'($urandom_range(0, 16)) - TICK_W'(8);
  endfunction

  function automatic sched_item_t random_item(input logic op);
    sched_item_t it;
    it.op           = op;
    it.slot         = SLOT_W'($urandom);
    it.present      = ($urandom_range(0, 7) != 0);
    it.ready        = ($urandom_range(0, 3) != 0);
    it.prio         = random_prio();
    it.periodic     = 1'($urandom_range(0, 1));
    it.release_tick = random_tick();
    it.now_tick     = random_tick();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: it.run = last_run;
      4, 5:       it.run = RUN_W'($urandom_range(0, 15));
      6:          it.run = NO_RUNNING;
      default:    it.run = RUN_W'($urandom_range(17, 31));
    endcase
    return it;
  endfunction

  // Stimulus
  initial begin : stimulus
    sched_item_t it;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_UPDATE;
    in_tdata  <= '0;
    tick_base = $urandom;
    for (int i = 0; i < MAX_TASKS_DEF; i++) begin
      sched_table[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      maybe_pause();
      offer_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random traffic, with one long receiver hold-off
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FROM) begin
        calm = 1'b1;
      end
      if (n == HOLD_AT) begin
        hold_req = 1'b1;
        for (int b = 0; b < HOLD_BURST; b++) begin
          offer_item(random_item(OP_SELECT), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 63) == 0) begin
        tick_base = $urandom;
      end else begin
        tick_base += TICK_W'($urandom_range(0, 3));
      end
      maybe_pause();
      it = random_item($urandom_range(0, 1) ? OP_SELECT : OP_UPDATE);
      offer_item(it, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain and settle
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side ready pattern
  initial begin : receiver
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare each taken result with the oldest predicted pick
  always @(posedge clk) begin : result_check
    sel_res_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_picks.size() == 0) begin
        flag_mismatch($sformatf("result with no select waiting: data %h idle %b",
                                out_tdata, out_tuser));
      end else begin
        want = pending_picks.pop_front();
        if (out_tdata[SLOT_W-1:0] !== want.slot) begin
          flag_mismatch($sformatf("chosen_slot %0d, predicted %0d",
                                  out_tdata[SLOT_W-1:0], want.slot));
        end
        if (out_tuser !== want.idle) begin
          flag_mismatch($sformatf("choose_idle %b, predicted %b", out_tuser, want.idle));
        end
        if (out_tdata[OUT_W-1:SLOT_W] !== '0) begin
          flag_mismatch($sformatf("padding bits %h not zero", out_tdata[OUT_W-1:SLOT_W]));
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
